// File: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Default sizes
  localparam int DSS_PATTERN_COUNT    = 16;
  localparam int DSS_INSTRUMENT_COUNT = 8;
  localparam int DSS_CHAIN_DEPTH      = 16;
  localparam int DSS_STEP_COUNT       = 16;

  // Reset value of the step period register
  localparam logic [15:0] DSS_PERIOD_RESET = 16'd8000;

  // Command codes
  typedef enum logic [3:0] {
    CMD_TICK         = 4'd0,
    CMD_PLAY         = 4'd1,
    CMD_PLAY_PATTERN = 4'd2,
    CMD_STOP         = 4'd3,
    CMD_SET_PENDING  = 4'd4,
    CMD_WRITE_BIT    = 4'd5,
    CMD_CLEAR        = 4'd6,
    CMD_SET_END      = 4'd7,
    CMD_CHAIN_ADD    = 4'd8,
    CMD_CHAIN_REMOVE = 4'd9,
    CMD_COPY         = 4'd10,
    CMD_READ         = 4'd11
  } dss_cmd_t;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ISSUE = 7'b0000100,
    ST_TICK  = 7'b0001000,
    ST_WBIT  = 7'b0010000,
    ST_WALK  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } dss_state_t;

endpackage

// File: src/drum_step_sequencer.sv
// ----------------------------------------------------------------------------
// drum_step_sequencer
// Pattern-based drum step sequencer with tempo countdown, pattern chain,
// pending pattern and pattern editing commands.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------
//  in      | in_cmd .. in_end_step                   | in_valid / in_stall
//  out     | out_fired .. out_is_playing             | out_valid / out_stall
//  cfg     | cfg_step_period_ticks                   | cfg_valid / cfg_ready
//
// Each input transaction is taken in IDLE and passes ISSUE, then FIN:
// transport, pending, chain and set_end commands go straight from ISSUE to
// FIN; tick and write_bit put one pattern RAM read in between and use it in
// TICK or WBIT; clear, copy and read walk the pattern RAM in WALK, one step
// word per cycle; a command that ends up doing nothing goes straight to FIN.
// After reset a clearing pass writes all PATTERN_COUNT*STEP_COUNT words
// (256 by default) before the first input transaction is taken.
// A finished result waits in the output register; the next input is taken
// meanwhile, its own result holds until the output register frees up.
// ----------------------------------------------------------------------------
module drum_step_sequencer
  import dss_pkg::*;
#(
  parameter int PATTERN_COUNT    = DSS_PATTERN_COUNT,
  parameter int INSTRUMENT_COUNT = DSS_INSTRUMENT_COUNT,
  parameter int CHAIN_DEPTH      = DSS_CHAIN_DEPTH,
  parameter int STEP_COUNT       = DSS_STEP_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_cmd,
  input  logic [3:0]        in_pattern,
  input  logic [3:0]        in_source_pattern,
  input  logic [3:0]        in_row,
  input  logic [3:0]        in_step,
  input  logic              in_bit_value,
  input  logic [4:0]        in_end_step,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_fired,
  output logic              out_accent,
  output logic [7:0]        out_triggers,
  output logic [3:0]        out_played_step,
  output logic [3:0]        out_played_pattern,
  output logic              out_pending_taken,
  output logic [15:0]       out_read_word,
  output logic [3:0]        out_now_step,
  output logic [3:0]        out_now_pattern,
  output logic signed [4:0] out_pending_out,
  output logic [4:0]        out_chain_count,
  output logic              out_is_playing,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_step_period_ticks
);

  // Derived sizes
  localparam int WW    = INSTRUMENT_COUNT + 1;
  localparam int RW    = $clog2(WW);
  localparam int PIW   = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
  localparam int SIW   = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam int EW    = $clog2(STEP_COUNT + 1);
  localparam int CPW   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int CLW   = $clog2(CHAIN_DEPTH + 1);
  localparam int DEPTH = PATTERN_COUNT * STEP_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Control registers
  dss_state_t       st_r, st_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [EW-1:0]    k_r, k_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [SIW-1:0]   rd_idx_r, rd_idx_nxt;

  // Sequencer state
  logic [15:0]      period_r;
  logic [15:0]      cd_r, cd_nxt;
  logic             playing_r, playing_nxt;
  logic [SIW-1:0]   step_pos_r, step_pos_nxt;
  logic [PIW-1:0]   cur_r, cur_nxt;
  logic [CPW-1:0]   chain_pos_r, chain_pos_nxt;
  logic [CLW-1:0]   chain_len_r, chain_len_nxt;
  logic [PIW-1:0]   chain0_r, chain0_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [PIW-1:0]   pend_r, pend_nxt;
  logic [EW-1:0]    ends_r [PATTERN_COUNT];
  logic [EW-1:0]    ends_nxt [PATTERN_COUNT];

  // Latched transaction fields
  dss_cmd_t         cmd_r;
  logic [3:0]       pat_in_r, src_in_r, row_r, step_in_r;
  logic             bitv_r;
  logic [4:0]       endv_r;

  // Result staging
  logic             res_fired_r, res_fired_nxt;
  logic             res_acc_r, res_acc_nxt;
  logic [7:0]       res_trig_r, res_trig_nxt;
  logic [SIW-1:0]   res_pstep_r, res_pstep_nxt;
  logic [PIW-1:0]   res_ppat_r, res_ppat_nxt;
  logic             res_taken_r, res_taken_nxt;
  logic [STEP_COUNT-1:0] rword_r, rword_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;

  // RAM ports
  logic             pm_we;
  logic [AW-1:0]    pm_waddr, pm_raddr;
  logic [WW-1:0]    pm_wdata, pm_rdata;
  logic             ch_we;
  logic [CPW-1:0]   ch_waddr, ch_raddr;
  logic [PIW-1:0]   ch_wdata, ch_rdata;

  // Decoded helpers
  logic             pat_ok, src_ok, row_ok, step_ok, in_acc;
  logic [PIW-1:0]   pat_idx, src_idx;
  logic [CLW-1:0]   np_full;
  logic [CPW-1:0]   np;
  logic [15:0]      cd_dec;
  logic             fire;
  logic [WW-1:0]    row_mask;

  dss_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  dss_ram #(.WIDTH(PIW), .DEPTH(CHAIN_DEPTH)) u_chain_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  // Field checks on the latched transaction
  assign pat_ok   = int'(pat_in_r) < PATTERN_COUNT;
  assign src_ok   = int'(src_in_r) < PATTERN_COUNT;
  assign row_ok   = int'(row_r) <= INSTRUMENT_COUNT;
  assign step_ok  = int'(step_in_r) < STEP_COUNT;
  assign pat_idx  = PIW'(pat_in_r);
  assign src_idx  = PIW'(src_in_r);
  assign row_mask = WW'(1) << row_r;

  // Next chain position, wraps at chain length or depth
  assign np_full = CLW'(chain_pos_r) + CLW'(1);
  assign np = (np_full >= chain_len_r || int'(np_full) >= CHAIN_DEPTH) ? '0 : CPW'(np_full);

  // Tempo countdown
  assign cd_dec = (cd_r != 16'd0) ? cd_r - 16'd1 : 16'd0;
  assign fire   = (cd_dec == 16'd0) && playing_r;

  // Handshakes
  assign in_stall  = (st_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_load  = (st_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Main sequencer
  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    cd_nxt        = cd_r;
    playing_nxt   = playing_r;
    step_pos_nxt  = step_pos_r;
    cur_nxt       = cur_r;
    chain_pos_nxt = chain_pos_r;
    chain_len_nxt = chain_len_r;
    chain0_nxt    = chain0_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    ends_nxt      = ends_r;
    res_fired_nxt = res_fired_r;
    res_acc_nxt   = res_acc_r;
    res_trig_nxt  = res_trig_r;
    res_pstep_nxt = res_pstep_r;
    res_ppat_nxt  = res_ppat_r;
    res_taken_nxt = res_taken_r;
    rword_nxt     = rword_r;
    pm_we         = 1'b0;
    pm_waddr      = '0;
    pm_wdata      = '0;
    pm_raddr      = '0;
    ch_we         = 1'b0;
    ch_waddr      = '0;
    ch_wdata      = '0;
    ch_raddr      = np;

    case (st_r)
      // Clearing pass over the pattern RAM
      ST_INIT: begin
        pm_we    = 1'b1;
        pm_waddr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (int'(clr_r) == DEPTH - 1) begin
          st_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          res_fired_nxt = 1'b0;
          res_acc_nxt   = 1'b0;
          res_trig_nxt  = '0;
          res_pstep_nxt = '0;
          res_ppat_nxt  = '0;
          res_taken_nxt = 1'b0;
          rword_nxt     = '0;
          k_nxt         = '0;
          st_nxt        = ST_ISSUE;
        end
      end

      // Decode, issue memory reads and chain RAM writes, apply register-only commands
      ST_ISSUE: begin
        st_nxt = ST_FIN;
        case (cmd_r)
          CMD_TICK: begin
            pm_raddr = AW'(cur_r) * AW'(STEP_COUNT) + AW'(step_pos_r);
            st_nxt   = ST_TICK;
          end
          CMD_PLAY: begin
            cd_nxt       = '0;
            step_pos_nxt = '0;
            playing_nxt  = 1'b1;
          end
          CMD_PLAY_PATTERN: begin
            if (pat_ok) begin
              cd_nxt       = '0;
              step_pos_nxt = '0;
              cur_nxt      = pat_idx;
              playing_nxt  = 1'b1;
              if (chain_len_r == CLW'(1)) begin
                chain0_nxt    = pat_idx;
                chain_pos_nxt = '0;
              end
            end
          end
          CMD_STOP: begin
            playing_nxt = 1'b0;
          end
          CMD_SET_PENDING: begin
            if (pat_ok) begin
              pend_nxt   = pat_idx;
              pend_v_nxt = 1'b1;
            end
          end
          CMD_WRITE_BIT: begin
            if (pat_ok && row_ok && step_ok) begin
              pm_raddr = AW'(pat_idx) * AW'(STEP_COUNT) + AW'(step_in_r);
              st_nxt   = ST_WBIT;
            end
          end
          CMD_CLEAR, CMD_COPY: begin
            if (pat_ok && (cmd_r == CMD_CLEAR || src_ok)) begin
              st_nxt = ST_WALK;
            end
          end
          CMD_SET_END: begin
            if (pat_ok) begin
              ends_nxt[pat_idx] = (int'(endv_r) > STEP_COUNT) ? EW'(STEP_COUNT) : EW'(endv_r);
            end
          end
          CMD_CHAIN_ADD: begin
            if (pat_ok && int'(chain_len_r) < CHAIN_DEPTH) begin
              ch_we         = 1'b1;
              ch_waddr      = CPW'(chain_len_r);
              ch_wdata      = pat_idx;
              chain_len_nxt = chain_len_r + CLW'(1);
            end
          end
          CMD_CHAIN_REMOVE: begin
            if (chain_len_r > CLW'(1)) begin
              chain_len_nxt = chain_len_r - CLW'(1);
            end
          end
          CMD_READ: begin
            if (pat_ok && row_ok) begin
              st_nxt = ST_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      // Step word and next chain entry are available
      ST_TICK: begin
        st_nxt = ST_FIN;
        cd_nxt = cd_dec;
        if (fire) begin
          cd_nxt        = period_r;
          res_fired_nxt = 1'b1;
          res_acc_nxt   = pm_rdata[INSTRUMENT_COUNT];
          res_trig_nxt  = 8'(pm_rdata[INSTRUMENT_COUNT-1:0]);
          res_pstep_nxt = step_pos_r;
          res_ppat_nxt  = cur_r;
          step_pos_nxt  = step_pos_r + SIW'(1);
          if (EW'(step_pos_r) + EW'(1) >= ends_r[cur_r]) begin
            step_pos_nxt = '0;
            if (pend_v_r) begin
              cur_nxt       = pend_r;
              pend_v_nxt    = 1'b0;
              res_taken_nxt = 1'b1;
              if (chain_len_r == CLW'(1)) begin
                chain0_nxt = pend_r;
              end
            end else begin
              chain_pos_nxt = np;
              cur_nxt       = (np == '0) ? chain0_r : ch_rdata;
            end
          end
        end
      end

      // Read-modify-write of one step word
      ST_WBIT: begin
        st_nxt   = ST_FIN;
        pm_we    = 1'b1;
        pm_waddr = AW'(pat_idx) * AW'(STEP_COUNT) + AW'(step_in_r);
        pm_wdata = bitv_r ? (pm_rdata | row_mask) : (pm_rdata & ~row_mask);
      end

      // Walk the step words of one pattern: clear, copy or read
      ST_WALK: begin
        if (cmd_r == CMD_CLEAR) begin
          pm_we    = 1'b1;
          pm_waddr = AW'(pat_idx) * AW'(STEP_COUNT) + AW'(k_r);
          k_nxt    = k_r + EW'(1);
          if (int'(k_r) == STEP_COUNT - 1) begin
            st_nxt = ST_FIN;
          end
        end else begin
          if (int'(k_r) < STEP_COUNT) begin
            pm_raddr   = ((cmd_r == CMD_COPY) ? AW'(src_idx) : AW'(pat_idx))
                         * AW'(STEP_COUNT) + AW'(k_r);
            k_nxt      = k_r + EW'(1);
            rd_v_nxt   = 1'b1;
            rd_idx_nxt = SIW'(k_r);
          end else if (!rd_v_r) begin
            st_nxt = ST_FIN;
            if (cmd_r == CMD_COPY) begin
              ends_nxt[pat_idx] = ends_r[src_idx];
            end
          end
          if (rd_v_r) begin
            if (cmd_r == CMD_COPY) begin
              pm_we    = 1'b1;
              pm_waddr = AW'(pat_idx) * AW'(STEP_COUNT) + AW'(rd_idx_r);
              pm_wdata = pm_rdata;
            end else begin
              rword_nxt[rd_idx_r] = pm_rdata[RW'(row_r)];
            end
          end
        end
      end

      // Hand the result to the output register
      ST_FIN: begin
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      clr_r       <= '0;
      rd_v_r      <= 1'b0;
      period_r    <= DSS_PERIOD_RESET;
      cd_r        <= '0;
      playing_r   <= 1'b0;
      step_pos_r  <= '0;
      cur_r       <= '0;
      chain_pos_r <= '0;
      chain_len_r <= CLW'(1);
      chain0_r    <= '0;
      pend_v_r    <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PATTERN_COUNT; i++) begin
        ends_r[i] <= EW'(STEP_COUNT);
      end
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      rd_v_r      <= rd_v_nxt;
      cd_r        <= cd_nxt;
      playing_r   <= playing_nxt;
      step_pos_r  <= step_pos_nxt;
      cur_r       <= cur_nxt;
      chain_pos_r <= chain_pos_nxt;
      chain_len_r <= chain_len_nxt;
      chain0_r    <= chain0_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      ends_r      <= ends_nxt;
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_step_period_ticks;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    rd_idx_r    <= rd_idx_nxt;
    res_fired_r <= res_fired_nxt;
    res_acc_r   <= res_acc_nxt;
    res_trig_r  <= res_trig_nxt;
    res_pstep_r <= res_pstep_nxt;
    res_ppat_r  <= res_ppat_nxt;
    res_taken_r <= res_taken_nxt;
    rword_r     <= rword_nxt;
    if (in_acc) begin
      cmd_r     <= dss_cmd_t'(in_cmd);
      pat_in_r  <= in_pattern;
      src_in_r  <= in_source_pattern;
      row_r     <= in_row;
      step_in_r <= in_step;
      bitv_r    <= in_bit_value;
      endv_r    <= in_end_step;
    end
    if (out_load) begin
      out_fired          <= res_fired_r;
      out_accent         <= res_acc_r;
      out_triggers       <= res_trig_r;
      out_played_step    <= 4'(res_pstep_r);
      out_played_pattern <= 4'(res_ppat_r);
      out_pending_taken  <= res_taken_r;
      out_read_word      <= 16'(rword_r);
      out_now_step       <= 4'(step_pos_r);
      out_now_pattern    <= 4'(cur_r);
      out_pending_out    <= pend_v_r ? $signed(5'(pend_r)) : -5'sd1;
      out_chain_count    <= 5'(chain_len_r);
      out_is_playing     <= playing_r;
    end
  end

  // Checks
  a_chain_len: assert property (@(posedge clk) disable iff (!rst_n)
    chain_len_r != '0 && int'(chain_len_r) <= CHAIN_DEPTH)
    else $error("chain length out of range");

  a_step_pos: assert property (@(posedge clk) disable iff (!rst_n)
    int'(step_pos_r) < STEP_COUNT)
    else $error("step position out of range");

  a_init_lock: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_INIT |-> in_stall)
    else $error("input taken during clearing pass");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_FIN))
    else $error("result presented outside finish state");

endmodule

// File: src/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
